/* design/bfxm_pkg.sv */
`timescale 1ns / 1ps
`default_nettype none

package bfxm_pkg;

    localparam int MAX_FILTER_BITS = 65536;
    localparam int MAX_MASKS       = 6;

    localparam int KEY_W      = 64;
    localparam int SIZE_W     = 17;
    localparam int MASK_W     = 16;
    localparam int COUNT_W    = 3;
    localparam int MASK_SLOTS = 6;
    localparam int CFG_IDX_W  = 3;
    localparam int CFG_DATA_W = 17;

    localparam logic [CFG_IDX_W-1:0] REG_FILTER_SIZE = 3'd0;
    localparam logic [CFG_IDX_W-1:0] REG_MASK_COUNT  = 3'd1;
    localparam logic [CFG_IDX_W-1:0] REG_MASK_ZERO   = 3'd2;

    localparam int RAM_W     = 32;
    localparam int BIT_W     = $clog2(RAM_W);
    localparam int RAM_DEPTH = (MAX_FILTER_BITS + RAM_W - 1) / RAM_W;
    localparam int ROW_AW    = $clog2(RAM_DEPTH);

    localparam int DIV_STEPS = KEY_W / 2;
    localparam int CNT_W     = $clog2(DIV_STEPS);

    typedef enum logic [2:0] {
        ST_CLEAR,
        ST_IDLE,
        ST_DIV,
        ST_READ,
        ST_CHECK,
        ST_DONE
    } state_t;

endpackage

`default_nettype wire

/* design/bfxm_ram.sv */
`timescale 1ns / 1ps
`default_nettype none

module bfxm_ram #(
    parameter int WIDTH  = 32,
    parameter int DEPTH  = 2048,
    parameter int ADDR_W = $clog2(DEPTH)
) (
    input  wire logic              clk,
    input  wire logic              we,
    input  wire logic [ADDR_W-1:0] waddr,
    input  wire logic [WIDTH-1:0]  wdata,
    input  wire logic              re,
    input  wire logic [ADDR_W-1:0] raddr,
    output logic      [WIDTH-1:0]  rdata
);

    logic [WIDTH-1:0] mem [DEPTH];

    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[waddr] <= wdata;
        end
        if (re)
        begin
            rdata <= mem[raddr];
        end
    end

endmodule

`default_nettype wire

/* design/bloom_filter_xor_masks_unit.sv */
`timescale 1ns / 1ps
`default_nettype none
// Each input beat makes n + 1 probes, n = masks in use (0..6).
// Each probe: the shared 2-bit-per-cycle remainder unit, then a row read and check.
// One item at a time: input stalls until the result register takes the last result.
// Reset: configuration returns to its defaults, then a clearing pass zeroes the
// 2048-row store while input stays stalled; config beats are taken throughout.

module bloom_filter_xor_masks_unit (
    input  wire logic                             clk,
    input  wire logic                             rst_n,
    input  wire logic                             in_valid,
    output logic                                  in_stall,
    input  wire logic                             action,
    input  wire logic [bfxm_pkg::KEY_W-1:0]       key_hash,
    output logic                                  out_valid,
    input  wire logic                             out_stall,
    output logic                                  possibly_present,
    input  wire logic                             cfg_valid,
    output logic                                  cfg_ready,
    input  wire logic [bfxm_pkg::CFG_IDX_W-1:0]   cfg_index,
    input  wire logic [bfxm_pkg::CFG_DATA_W-1:0]  cfg_data
);

    import bfxm_pkg::*;

    state_t              state_reg, state_next;
    logic [SIZE_W-1:0]   size_reg;
    logic [COUNT_W-1:0]  count_reg;
    logic [MASK_W-1:0]   mask_reg [MASK_SLOTS];
    logic [ROW_AW-1:0]   clr_reg, clr_next;
    logic [CNT_W-1:0]    cnt_reg, cnt_next;
    logic [COUNT_W-1:0]  probe_reg, probe_next;
    logic                all_reg, all_next;
    logic                query_reg, query_next;
    logic                out_valid_reg, out_valid_next;
    logic                present_reg, present_next;
    logic [KEY_W-1:0]    key_reg, key_next;
    logic [KEY_W-1:0]    dvd_reg, dvd_next;
    logic [SIZE_W-1:0]   rem_reg, rem_next;

    logic [SIZE_W-1:0]   use_size;
    logic [COUNT_W-1:0]  use_masks;
    logic [SIZE_W:0]     t1, t2;
    logic [SIZE_W-1:0]   r1, r2;
    logic                in_beat;

    logic                ram_we, ram_re;
    logic [ROW_AW-1:0]   ram_waddr, ram_raddr, probe_row;
    logic [RAM_W-1:0]    ram_wdata, ram_rdata;
    logic [BIT_W-1:0]    probe_bit;

    bfxm_ram #(
        .WIDTH (RAM_W),
        .DEPTH (RAM_DEPTH)
    ) u_store (
        .clk   (clk),
        .we    (ram_we),
        .waddr (ram_waddr),
        .wdata (ram_wdata),
        .re    (ram_re),
        .raddr (ram_raddr),
        .rdata (ram_rdata)
    );

    assign cfg_ready        = 1'b1;
    assign in_stall         = (state_reg != ST_IDLE);
    assign in_beat          = in_valid && !in_stall;
    assign out_valid        = out_valid_reg;
    assign possibly_present = present_reg;

    always_comb
    begin
        if (size_reg == '0)
        begin
            use_size = SIZE_W'(1);
        end
        else if (32'(size_reg) > MAX_FILTER_BITS)
        begin
            use_size = SIZE_W'(MAX_FILTER_BITS);
        end
        else
        begin
            use_size = size_reg;
        end
        if (32'(count_reg) > MAX_MASKS)
        begin
            use_masks = COUNT_W'(MAX_MASKS);
        end
        else
        begin
            use_masks = count_reg;
        end
    end

    // two restoring remainder steps per cycle
    always_comb
    begin
        t1 = {rem_reg, dvd_reg[KEY_W-1]};
        if (t1 >= {1'b0, use_size})
        begin
            t1 = t1 - {1'b0, use_size};
        end
        r1 = t1[SIZE_W-1:0];
        t2 = {r1, dvd_reg[KEY_W-2]};
        if (t2 >= {1'b0, use_size})
        begin
            t2 = t2 - {1'b0, use_size};
        end
        r2 = t2[SIZE_W-1:0];
    end

    assign probe_row = ROW_AW'(rem_reg >> BIT_W);
    assign probe_bit = rem_reg[BIT_W-1:0];

    always_comb
    begin
        state_next     = state_reg;
        clr_next       = clr_reg;
        cnt_next       = cnt_reg;
        probe_next     = probe_reg;
        all_next       = all_reg;
        query_next     = query_reg;
        key_next       = key_reg;
        dvd_next       = dvd_reg;
        rem_next       = rem_reg;
        present_next   = present_reg;
        out_valid_next = out_valid_reg && out_stall;
        ram_we         = 1'b0;
        ram_waddr      = probe_row;
        ram_wdata      = ram_rdata | (RAM_W'(1) << probe_bit);
        ram_re         = 1'b0;
        ram_raddr      = probe_row;

        unique case (state_reg)
            ST_CLEAR:
            begin
                ram_we    = 1'b1;
                ram_waddr = clr_reg;
                ram_wdata = '0;
                clr_next  = clr_reg + ROW_AW'(1);
                if (32'(clr_reg) == RAM_DEPTH - 1)
                begin
                    state_next = ST_IDLE;
                end
            end
            ST_IDLE:
            begin
                if (in_beat)
                begin
                    query_next = action;
                    key_next   = key_hash;
                    dvd_next   = key_hash;
                    rem_next   = '0;
                    cnt_next   = '0;
                    probe_next = '0;
                    all_next   = 1'b1;
                    state_next = ST_DIV;
                end
            end
            ST_DIV:
            begin
                rem_next = r2;
                dvd_next = dvd_reg << 2;
                cnt_next = cnt_reg + CNT_W'(1);
                if (32'(cnt_reg) == DIV_STEPS - 1)
                begin
                    state_next = ST_READ;
                end
            end
            ST_READ:
            begin
                ram_re     = 1'b1;
                state_next = ST_CHECK;
            end
            ST_CHECK:
            begin
                ram_we   = !query_reg;
                all_next = all_reg && (ram_rdata[probe_bit] || !query_reg);
                if (probe_reg == use_masks)
                begin
                    state_next = ST_DONE;
                end
                else
                begin
                    dvd_next   = key_reg ^ KEY_W'(mask_reg[probe_reg]);
                    rem_next   = '0;
                    cnt_next   = '0;
                    probe_next = probe_reg + COUNT_W'(1);
                    state_next = ST_DIV;
                end
            end
            ST_DONE:
            begin
                if (!out_valid_reg || !out_stall)
                begin
                    out_valid_next = 1'b1;
                    present_next   = query_reg && all_reg;
                    state_next     = ST_IDLE;
                end
            end
            default:
            begin
                state_next = ST_CLEAR;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= ST_CLEAR;
            clr_reg       <= '0;
            cnt_reg       <= '0;
            probe_reg     <= '0;
            all_reg       <= 1'b0;
            query_reg     <= 1'b0;
            out_valid_reg <= 1'b0;
            size_reg      <= SIZE_W'(65536);
            count_reg     <= COUNT_W'(3);
            for (int i = 0; i < MASK_SLOTS; i++)
            begin
                mask_reg[i] <= '0;
            end
        end
        else
        begin
            state_reg     <= state_next;
            clr_reg       <= clr_next;
            cnt_reg       <= cnt_next;
            probe_reg     <= probe_next;
            all_reg       <= all_next;
            query_reg     <= query_next;
            out_valid_reg <= out_valid_next;
            if (cfg_valid && cfg_ready)
            begin
                unique case (cfg_index)
                    REG_FILTER_SIZE:
                    begin
                        size_reg <= cfg_data[SIZE_W-1:0];
                    end
                    REG_MASK_COUNT:
                    begin
                        count_reg <= cfg_data[COUNT_W-1:0];
                    end
                    default:
                    begin
                        mask_reg[CFG_IDX_W'(cfg_index - REG_MASK_ZERO)] <= cfg_data[MASK_W-1:0];
                    end
                endcase
            end
        end
    end

    always_ff @(posedge clk)
    begin
        key_reg     <= key_next;
        dvd_reg     <= dvd_next;
        rem_reg     <= rem_next;
        present_reg <= present_next;
    end

    a_no_result_in_clear: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == ST_CLEAR) |-> !out_valid_reg)
        else $error("result beat during store clear");

    a_accept_starts_div: assert property (@(posedge clk) disable iff (!rst_n)
        in_beat |=> (state_reg == ST_DIV))
        else $error("accepted beat did not start the remainder unit");

    a_check_after_read: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == ST_CHECK) |-> ($past(state_reg) == ST_READ))
        else $error("probe check without a row read");

    a_result_from_done: assert property (@(posedge clk) disable iff (!rst_n)
        $rose(out_valid_reg) |-> ($past(state_reg) == ST_DONE))
        else $error("result raised outside completion");

endmodule

`default_nettype wire

/* sim/testbench.sv */
`timescale 1ns / 1ps

module testbench;
    import bfxm_pkg::*;

    localparam logic ACT_INSERT = 1'b0;
    localparam logic ACT_QUERY  = 1'b1;

    typedef struct packed {
        logic        act;
        logic [63:0] key;
    } key_beat_t;

    logic                  clk = 1'b0;
    logic                  rst_n = 1'b0;
    logic                  in_valid = 1'b0;
    logic                  in_stall;
    logic                  action = ACT_INSERT;
    logic [KEY_W-1:0]      key_hash = '0;
    logic                  out_valid;
    logic                  out_stall = 1'b0;
    logic                  possibly_present;
    logic                  cfg_valid = 1'b0;
    logic                  cfg_ready;
    logic [CFG_IDX_W-1:0]  cfg_index = '0;
    logic [CFG_DATA_W-1:0] cfg_data = '0;

    bloom_filter_xor_masks_unit dut (.*);

    // shadow copy of the block
    bit              shadow_bits [0:MAX_FILTER_BITS-1];
    logic [SIZE_W-1:0]  size_reg = 17'd65536;
    logic [COUNT_W-1:0] count_reg = 3'd3;
    logic [MASK_W-1:0]  mask_reg [MASK_SLOTS];

    key_beat_t   key_backlog [$];
    logic        presence_due [$];
    logic [63:0] recent_keys [$];
    key_beat_t   next_beat;
    int          errors = 0;
    int          results_seen = 0;
    int          rx_hold_left = 0;
    bit          rx_hold_used = 1'b0;
    bit          quiet_tx = 1'b0;
    bit          quiet_rx = 1'b0;

    always #5 clk = ~clk;

    function automatic logic probe_filter(input logic act, input logic [63:0] key);
        logic [63:0] span;
        logic [63:0] slot;
        int          n;
        logic        all_set;
        span = 64'(size_reg);
        if (span == 64'd0)
            span = 64'd1;
        if (span > 64'(MAX_FILTER_BITS))
            span = 64'(MAX_FILTER_BITS);
        n = (count_reg > MAX_MASKS) ? MAX_MASKS : count_reg;
        all_set = 1'b1;
        for (int i = 0; i <= n; i++)
        begin
            if (i == 0)
                slot = key % span;
            else
                slot = (key ^ 64'(mask_reg[i-1])) % span;
            if (act == ACT_INSERT)
                shadow_bits[slot] = 1'b1;
            all_set = all_set & shadow_bits[slot];
        end
        return (act == ACT_QUERY) && all_set;
    endfunction

    // driver
    always @(posedge clk)
    begin
        if (!rst_n)
        begin
            in_valid <= 1'b0;
        end
        else
        begin
            if (in_valid && !in_stall)
                presence_due.insert(presence_due.size(), probe_filter(action, key_hash));
            if (!in_valid || !in_stall)
            begin
                if (key_backlog.size() != 0 && (quiet_tx || $urandom_range(99) >= 26))
                begin
                    next_beat = key_backlog.pop_front();
                    in_valid <= 1'b1;
                    action   <= next_beat.act;
                    key_hash <= next_beat.key;
                end
                else
                begin
                    in_valid <= 1'b0;
                end
            end
        end
    end

    // monitor
    always @(posedge clk)
    begin
        if (rst_n)
        begin
            if (out_valid && !out_stall)
            begin
                if (presence_due.size() == 0)
                begin
                    errors++;
                    $display("%0t: possibly_present expected none actual %0b",
                             $time, possibly_present);
                end
                else if (presence_due[0] !== possibly_present)
                begin
                    errors++;
                    $display("%0t: possibly_present expected %0b actual %0b",
                             $time, presence_due[0], possibly_present);
                    void'(presence_due.pop_front());
                end
                else
                begin
                    void'(presence_due.pop_front());
                end
                results_seen++;
            end
            // hold off once for a long stretch so the block backs up
            if (!rx_hold_used && results_seen == 350)
            begin
                rx_hold_used = 1'b1;
                rx_hold_left = 3000;
            end
            if (rx_hold_left > 0)
            begin
                rx_hold_left--;
                out_stall <= 1'b1;
            end
            else
            begin
                out_stall <= !quiet_rx && ($urandom_range(99) < 26);
            end
        end
    end

    task automatic write_reg(input logic [CFG_IDX_W-1:0] idx,
                             input logic [CFG_DATA_W-1:0] data);
        @(posedge clk);
        cfg_valid <= 1'b1;
        cfg_index <= idx;
        cfg_data  <= data;
        do @(posedge clk); while (!cfg_ready);
        cfg_valid <= 1'b0;
        if (idx == REG_FILTER_SIZE)
            size_reg = data;
        else if (idx == REG_MASK_COUNT)
            count_reg = data[COUNT_W-1:0];
        else
            mask_reg[idx - REG_MASK_ZERO] = data[MASK_W-1:0];
        @(negedge clk);
    endtask

    task automatic settle();
        do @(negedge clk);
        while (key_backlog.size() != 0 || in_valid || presence_due.size() != 0);
    endtask

    task automatic add(input logic act, input logic [63:0] key);
        key_beat_t item;
        item.act = act;
        item.key = key;
        key_backlog.insert(key_backlog.size(), item);
        if (act == ACT_INSERT)
        begin
            recent_keys.insert(recent_keys.size(), key);
            if (recent_keys.size() > 64)
                void'(recent_keys.pop_front());
        end
    endtask

    task automatic shuffle_config(input logic [SIZE_W-1:0] size, input logic [2:0] count);
        write_reg(REG_FILTER_SIZE, size);
        write_reg(REG_MASK_COUNT, 17'(count));
        for (int i = 0; i < MASK_SLOTS; i++)
            write_reg(CFG_IDX_W'(REG_MASK_ZERO + i), 17'($urandom_range(131071)));
    endtask

    task automatic push_random(input int count, input int query_pct);
        logic        r_act;
        logic [63:0] r_key;
        for (int k = 0; k < count; k++)
        begin
            r_act = ($urandom_range(99) < query_pct) ? ACT_QUERY : ACT_INSERT;
            if (r_act == ACT_QUERY && recent_keys.size() != 0 && $urandom_range(99) < 60)
            begin
                r_key = recent_keys[$urandom_range(recent_keys.size() - 1)];
                // near miss
                if ($urandom_range(3) == 0)
                    r_key[$urandom_range(63)] = ~r_key[$urandom_range(63)];
            end
            else
            begin
                r_key = {$urandom, $urandom};
                if ($urandom_range(3) == 0)
                    r_key = r_key >> $urandom_range(63);
            end
            add(r_act, r_key);
        end
    endtask

    initial
    begin
        logic [CFG_DATA_W-1:0] corner_masks [MASK_SLOTS];
        corner_masks = '{17'h1FFFF, 17'h00001, 17'h08000, 17'h05555, 17'h0AAAA, 17'h00000};
        foreach (mask_reg[i])
            mask_reg[i] = '0;
        repeat (4) @(posedge clk);
        @(negedge clk);
        rst_n = 1'b1;

        // reset settings: all masks zero, so every probe repeats the same bit
        add(ACT_QUERY, 64'd0);
        add(ACT_INSERT, 64'd0);
        add(ACT_QUERY, 64'd0);
        add(ACT_QUERY, 64'hFFFF_FFFF_FFFF_FFFF);
        add(ACT_INSERT, 64'hFFFF_FFFF_FFFF_FFFF);
        add(ACT_QUERY, 64'hFFFF_FFFF_FFFF_FFFF);
        add(ACT_INSERT, 64'h8000_0000_0000_0000);
        add(ACT_QUERY, 64'h8000_0000_0000_0000);
        settle();

        for (int i = 0; i < MASK_SLOTS; i++)
            write_reg(CFG_IDX_W'(REG_MASK_ZERO + i), corner_masks[i]);
        write_reg(REG_MASK_COUNT, 17'd6);
        add(ACT_INSERT, 64'h0123_4567_89AB_CDEF);
        add(ACT_QUERY, 64'h0123_4567_89AB_CDEF);
        add(ACT_QUERY, 64'h0123_4567_89AB_CDEE);
        add(ACT_QUERY, 64'hFEDC_BA98_7654_3210);
        settle();

        // oversized size and mask count
        write_reg(REG_FILTER_SIZE, 17'h1FFFF);
        write_reg(REG_MASK_COUNT, 17'd7);
        add(ACT_INSERT, 64'hFFFF_0000_FFFF_0000);
        add(ACT_QUERY, 64'hFFFF_0000_FFFF_0000);
        add(ACT_QUERY, 64'h0000_FFFF_0000_FFFF);
        settle();

        write_reg(REG_FILTER_SIZE, 17'd0);
        write_reg(REG_MASK_COUNT, 17'd0);
        add(ACT_QUERY, 64'h0000_0000_DEAD_BEEF);
        add(ACT_INSERT, {$urandom, $urandom});
        settle();

        write_reg(REG_FILTER_SIZE, 17'd1);
        add(ACT_QUERY, {$urandom, $urandom});
        settle();

        // shrink without clearing the store
        write_reg(REG_FILTER_SIZE, 17'd100);
        write_reg(REG_MASK_COUNT, 17'd2);
        add(ACT_QUERY, 64'h0123_4567_89AB_CDEF);
        add(ACT_QUERY, 64'd0);
        add(ACT_INSERT, 64'h0000_0000_0000_FFFF);
        add(ACT_QUERY, 64'h0000_0000_0000_FFFF);
        settle();

        write_reg(REG_FILTER_SIZE, 17'd65535);
        write_reg(REG_MASK_COUNT, 17'd1);
        write_reg(REG_MASK_ZERO, 17'd0);
        add(ACT_QUERY, 64'hFFFF_FFFF_FFFF_FFFF);
        add(ACT_INSERT, 64'd65534);
        add(ACT_QUERY, 64'd65534);

        for (int p = 0; p < 6; p++)
        begin
            settle();
            case (p)
                0: shuffle_config(17'($urandom_range(65536, 1)), 3'd3);
                1: shuffle_config(17'($urandom_range(64, 1)), 3'd6);
                2: shuffle_config(17'd65536, 3'd0);
                3: shuffle_config(17'($urandom_range(131071, 65537)), 3'd7);
                4: shuffle_config(17'($urandom_range(1000)), 3'($urandom_range(7)));
                default: shuffle_config(17'($urandom_range(131071)), 3'($urandom_range(7)));
            endcase
            quiet_tx = (p == 2);
            quiet_rx = (p == 2);
            if (p == 3)
            begin
                // pause the sender until every result is back
                push_random(100, 50);
                settle();
                push_random(100, 50);
            end
            else
            begin
                push_random(200, 50);
            end
        end

        settle();
        repeat (300) @(negedge clk);
        if (errors == 0)
            $display("testbench passed");
        else
            $display("testbench failed");
        $finish;
    end

    initial
    begin
        #30_000_000;
        $display("testbench failed");
        $finish;
    end

endmodule
